// ===== src/qrs_pkg.sv =====
// Shared types and constants for the quadratic root solver.
// No dependencies; used by every module of the block.
`default_nettype none

package qrs_pkg;

    localparam int COEF_W    = 16;
    localparam int EPS_W     = 15;
    localparam int DISC_W    = 35;
    localparam int SQRT_IN_W = 64;
    localparam int SQRT_W    = 32;
    localparam int NUM_W     = 34;
    localparam int QUOT_W    = 35;

    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;
    localparam logic [1:0] CNT_INF  = 2'd3;

    localparam logic REG_EPSILON = 1'b0;

    // Which divisions an item needs.
    typedef enum logic [2:0] {
        KIND_NONE = 3'd0,
        KIND_LIN  = 3'd1,
        KIND_CZ2  = 3'd2,
        KIND_DBL  = 3'd3,
        KIND_TWO  = 3'd4
    } kind_t;

    typedef struct packed {
        logic [1:0]              count;
        kind_t                   kind;
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
    } sq_side_t;

endpackage

`default_nettype wire

// ===== src/qrs_sqrt_pipe.sv =====
// Pipelined digit-by-digit integer square root, one result bit per stage.
// Depends on qrs_pkg for widths.
`default_nettype none

module qrs_sqrt_pipe #(
    parameter int SIDE_W = 1
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic [qrs_pkg::SQRT_IN_W-1:0]  radicand,
    input  wire logic [SIDE_W-1:0]              side_in,
    output logic                                out_valid,
    output logic [qrs_pkg::SQRT_W-1:0]          root,
    output logic [SIDE_W-1:0]                   side_out
);

    localparam int STAGES = qrs_pkg::SQRT_W;
    localparam int RW     = qrs_pkg::SQRT_W + 2;

    logic                            valid_reg [STAGES];
    logic [qrs_pkg::SQRT_IN_W-1:0]   rad_reg   [STAGES];
    logic [RW-1:0]                   rem_reg   [STAGES];
    logic [qrs_pkg::SQRT_W-1:0]      root_reg  [STAGES];
    logic [SIDE_W-1:0]               side_reg  [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic                          v_in;
        logic [qrs_pkg::SQRT_IN_W-1:0] rad_in;
        logic [RW-1:0]                 rem_in;
        logic [qrs_pkg::SQRT_W-1:0]    root_in;
        logic [SIDE_W-1:0]             side_k;
        logic [RW+1:0]                 rem_shift;
        logic [RW+1:0]                 trial;
        logic                          take;
        logic [RW-1:0]                 rem_next;
        logic [qrs_pkg::SQRT_W-1:0]    root_next;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign rad_in  = radicand;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_k  = side_in;
        end
        else begin : g_rest
            assign v_in    = valid_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign side_k  = side_reg[k-1];
        end

        always_comb
        begin
            rem_shift = {rem_in, rad_in[qrs_pkg::SQRT_IN_W-1 -: 2]};
            trial     = {2'b00, root_in, 2'b01};
            take      = (rem_shift >= trial);
            rem_next  = take ? RW'(rem_shift - trial) : RW'(rem_shift);
            root_next = {root_in[qrs_pkg::SQRT_W-2:0], take};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rad_reg[k]  <= {rad_in[qrs_pkg::SQRT_IN_W-3:0], 2'b00};
            rem_reg[k]  <= rem_next;
            root_reg[k] <= root_next;
            side_reg[k] <= side_k;
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign root      = root_reg[STAGES-1];
    assign side_out  = side_reg[STAGES-1];

endmodule

`default_nettype wire

// ===== src/qrs_div_pipe.sv =====
// Pipelined signed divider that rounds to nearest, ties away from zero.
// One quotient bit per stage after the input register; depends on qrs_pkg for widths.
`default_nettype none

module qrs_div_pipe #(
    parameter int SIDE_W = 1
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire logic signed [qrs_pkg::NUM_W-1:0]  num,
    input  wire logic signed [qrs_pkg::COEF_W-1:0] den,
    input  wire logic [SIDE_W-1:0]                 side_in,
    output logic                                   out_valid,
    output logic signed [qrs_pkg::QUOT_W-1:0]      quot,
    output logic [SIDE_W-1:0]                      side_out
);

    localparam int NW     = qrs_pkg::NUM_W;
    localparam int DW     = qrs_pkg::COEF_W + 1;
    localparam int STAGES = NW + 1;

    logic              valid_reg [STAGES];
    logic [NW-1:0]     nq_reg    [STAGES];
    logic [DW-1:0]     dv_reg    [STAGES];
    logic [DW-1:0]     rem_reg   [STAGES];
    logic              neg_reg   [STAGES];
    logic [SIDE_W-1:0] side_reg  [STAGES];

    logic [NW-2:0]                 n_mag;
    logic [qrs_pkg::COEF_W-1:0]    d_mag;
    logic [NW-1:0]                 dividend;

    // Rounding: floor((2|n| + |d|) / (2|d|)).
    always_comb
    begin
        n_mag    = num[NW-1] ? (NW-1)'(-num) : (NW-1)'(num);
        d_mag    = den[qrs_pkg::COEF_W-1] ? qrs_pkg::COEF_W'(-den) : qrs_pkg::COEF_W'(den);
        dividend = {n_mag, 1'b0} + NW'(d_mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        nq_reg[0]   <= dividend;
        dv_reg[0]   <= {d_mag, 1'b0};
        rem_reg[0]  <= '0;
        neg_reg[0]  <= num[NW-1] ^ den[qrs_pkg::COEF_W-1];
        side_reg[0] <= side_in;
    end

    for (genvar k = 1; k < STAGES; k++) begin : g_stage
        logic [DW:0]   rem_shift;
        logic          take;
        logic [DW-1:0] rem_next;
        logic [NW-1:0] nq_next;

        always_comb
        begin
            rem_shift = {rem_reg[k-1], nq_reg[k-1][NW-1]};
            take      = (rem_shift >= {1'b0, dv_reg[k-1]});
            rem_next  = take ? DW'(rem_shift - {1'b0, dv_reg[k-1]}) : DW'(rem_shift);
            nq_next   = {nq_reg[k-1][NW-2:0], take};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            nq_reg[k]   <= nq_next;
            dv_reg[k]   <= dv_reg[k-1];
            rem_reg[k]  <= rem_next;
            neg_reg[k]  <= neg_reg[k-1];
            side_reg[k] <= side_reg[k-1];
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign quot      = neg_reg[STAGES-1] ? -$signed({1'b0, nq_reg[STAGES-1]})
                                         :  $signed({1'b0, nq_reg[STAGES-1]});
    assign side_out  = side_reg[STAGES-1];

endmodule

`default_nettype wire

// ===== src/quadratic_root_solver.sv =====
// Quadratic root solver: real roots of a*x^2+b*x+c, Q8.8 in, Q16.16 out.
// The pipeline holds the 32-stage square root and the 35-stage rounding
// dividers; one item is accepted every cycle.
// busy is never raised and the receiver cannot stall the pipeline.
// Reset clears all valid bits and sets epsilon to 1.
// Depends on qrs_pkg, qrs_sqrt_pipe and qrs_div_pipe.
`default_nettype none

module quadratic_root_solver #(
    parameter int COEF_FRAC_BITS = 8,
    parameter int ROOT_WIDTH     = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [2:0]                        paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic signed [qrs_pkg::COEF_W-1:0] coef_a,
    input  wire logic signed [qrs_pkg::COEF_W-1:0] coef_b,
    input  wire logic signed [qrs_pkg::COEF_W-1:0] coef_c,
    output logic                                   done,
    output logic [1:0]                             root_count,
    output logic signed [ROOT_WIDTH-1:0]           root_one,
    output logic signed [ROOT_WIDTH-1:0]           root_two,
    output logic                                   saturated
);

    localparam int CW      = qrs_pkg::COEF_W;
    localparam int DW      = qrs_pkg::DISC_W;
    localparam int NW      = qrs_pkg::NUM_W;
    localparam int LATENCY = 72;
    localparam logic signed [63:0] ROOT_MAX = (64'sd1 <<< (ROOT_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] ROOT_MIN = -ROOT_MAX - 64'sd1;

    // Configuration.
    logic [qrs_pkg::EPS_W-1:0] eps_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == qrs_pkg::REG_EPSILON) ? {17'b0, eps_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= 15'd1;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == qrs_pkg::REG_EPSILON)
        begin
            eps_reg <= pwdata[qrs_pkg::EPS_W-1:0];
        end
    end

    assign busy = 1'b0;

    // Stage 1: capture coefficients.
    logic                 s1_v_reg;
    logic signed [CW-1:0] s1_a_reg, s1_b_reg, s1_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_a_reg <= coef_a;
        s1_b_reg <= coef_b;
        s1_c_reg <= coef_c;
    end

    // Stage 2: products and near-zero flags.
    logic                   s2_v_reg;
    logic signed [2*CW-1:0] s2_bb_reg, s2_ac_reg;
    logic signed [CW-1:0]   s2_a_reg, s2_b_reg, s2_c_reg;
    logic                   s2_a_near_reg, s2_b_near_reg, s2_b_ge_reg, s2_c_near_reg;
    logic [CW-1:0]          abs_a, abs_b, abs_c;

    always_comb
    begin
        abs_a = s1_a_reg[CW-1] ? CW'(-s1_a_reg) : CW'(s1_a_reg);
        abs_b = s1_b_reg[CW-1] ? CW'(-s1_b_reg) : CW'(s1_b_reg);
        abs_c = s1_c_reg[CW-1] ? CW'(-s1_c_reg) : CW'(s1_c_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_bb_reg     <= s1_b_reg * s1_b_reg;
        s2_ac_reg     <= s1_a_reg * s1_c_reg;
        s2_a_reg      <= s1_a_reg;
        s2_b_reg      <= s1_b_reg;
        s2_c_reg      <= s1_c_reg;
        s2_a_near_reg <= abs_a <= {1'b0, eps_reg};
        s2_b_near_reg <= abs_b <= {1'b0, eps_reg};
        s2_b_ge_reg   <= abs_b >= {1'b0, eps_reg};
        s2_c_near_reg <= abs_c <= {1'b0, eps_reg};
    end

    // Stage 3: discriminant and case selection, feeding the square root.
    logic signed [DW-1:0]  disc;
    logic [DW-1:0]         abs_disc;
    logic signed [DW-1:0]  eps_disc;
    qrs_pkg::sq_side_t     sq_side_next;
    logic [qrs_pkg::SQRT_IN_W-1:0] rad_next;

    always_comb
    begin
        disc     = DW'(s2_bb_reg) - (DW'(s2_ac_reg) <<< 2);
        abs_disc = disc[DW-1] ? DW'(-disc) : DW'(disc);
        eps_disc = $signed(DW'(eps_reg) << COEF_FRAC_BITS);
        sq_side_next.a = s2_a_reg;
        sq_side_next.b = s2_b_reg;
        sq_side_next.c = s2_c_reg;
        sq_side_next.count = qrs_pkg::CNT_NONE;
        sq_side_next.kind  = qrs_pkg::KIND_NONE;
        if (s2_a_near_reg)
        begin
            if (s2_b_near_reg)
            begin
                sq_side_next.count = s2_c_near_reg ? qrs_pkg::CNT_INF : qrs_pkg::CNT_NONE;
            end
            else
            begin
                sq_side_next.count = qrs_pkg::CNT_ONE;
                sq_side_next.kind  = qrs_pkg::KIND_LIN;
            end
        end
        else if (s2_c_near_reg)
        begin
            if (s2_b_ge_reg)
            begin
                sq_side_next.count = qrs_pkg::CNT_TWO;
                sq_side_next.kind  = qrs_pkg::KIND_CZ2;
            end
            else
            begin
                sq_side_next.count = qrs_pkg::CNT_ONE;
            end
        end
        else if (abs_disc <= DW'(eps_disc))
        begin
            sq_side_next.count = qrs_pkg::CNT_ONE;
            sq_side_next.kind  = qrs_pkg::KIND_DBL;
        end
        else if (disc > eps_disc)
        begin
            sq_side_next.count = qrs_pkg::CNT_TWO;
            sq_side_next.kind  = qrs_pkg::KIND_TWO;
        end
        // The radicand takes 30 extra fraction bits, so the root gains 15.
        rad_next = (sq_side_next.kind == qrs_pkg::KIND_TWO)
                   ? {1'b0, disc[32:0], 30'b0} : '0;
    end

    logic                   s3_v_reg;
    qrs_pkg::sq_side_t      s3_side_reg;
    logic [qrs_pkg::SQRT_IN_W-1:0] s3_rad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
        end
        else
        begin
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_side_reg <= sq_side_next;
        s3_rad_reg  <= rad_next;
    end

    logic                        sq_v;
    logic [qrs_pkg::SQRT_W-1:0]  sq_root;
    logic [$bits(qrs_pkg::sq_side_t)-1:0] sq_side_bits;
    qrs_pkg::sq_side_t           sq_side;

    qrs_sqrt_pipe #(
        .SIDE_W ($bits(qrs_pkg::sq_side_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_v_reg),
        .radicand  (s3_rad_reg),
        .side_in   (s3_side_reg),
        .out_valid (sq_v),
        .root      (sq_root),
        .side_out  (sq_side_bits)
    );

    assign sq_side = qrs_pkg::sq_side_t'(sq_side_bits);

    // Stage 4: numerators and denominators for the two division lanes.
    logic signed [NW-1:0] b_ext, c_ext, s_ext, neg_b_half, num1_next, num2_next;
    logic signed [CW-1:0] den1_next;
    logic                 en1_next, en2_next;

    always_comb
    begin
        b_ext      = NW'(sq_side.b);
        c_ext      = NW'(sq_side.c);
        s_ext      = $signed({2'b00, sq_root});
        neg_b_half = -(b_ext <<< 15);
        num1_next  = '0;
        num2_next  = '0;
        den1_next  = sq_side.a;
        en1_next   = 1'b0;
        en2_next   = 1'b0;
        case (sq_side.kind)
            qrs_pkg::KIND_LIN:
            begin
                num1_next = -(c_ext <<< 16);
                den1_next = sq_side.b;
                en1_next  = 1'b1;
            end
            qrs_pkg::KIND_CZ2:
            begin
                num2_next = -(b_ext <<< 16);
                en2_next  = 1'b1;
            end
            qrs_pkg::KIND_DBL:
            begin
                num1_next = neg_b_half;
                en1_next  = 1'b1;
            end
            qrs_pkg::KIND_TWO:
            begin
                num1_next = neg_b_half - s_ext;
                num2_next = neg_b_half + s_ext;
                en1_next  = 1'b1;
                en2_next  = 1'b1;
            end
            default:
            begin
                en1_next = 1'b0;
            end
        endcase
    end

    logic                 s4_v_reg;
    logic signed [NW-1:0] s4_num1_reg, s4_num2_reg;
    logic signed [CW-1:0] s4_den1_reg, s4_den2_reg;
    logic                 s4_en1_reg, s4_en2_reg;
    logic [1:0]           s4_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_v_reg <= 1'b0;
        end
        else
        begin
            s4_v_reg <= sq_v;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_num1_reg  <= num1_next;
        s4_num2_reg  <= num2_next;
        s4_den1_reg  <= den1_next;
        s4_den2_reg  <= sq_side.a;
        s4_en1_reg   <= en1_next;
        s4_en2_reg   <= en2_next;
        s4_count_reg <= sq_side.count;
    end

    logic                                 d1_v, d2_v;
    logic signed [qrs_pkg::QUOT_W-1:0]    q1, q2;
    logic [2:0]                           d1_side;
    logic                                 d2_side;

    qrs_div_pipe #(
        .SIDE_W (3)
    ) u_div_one (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s4_v_reg),
        .num       (s4_num1_reg),
        .den       (s4_den1_reg),
        .side_in   ({s4_count_reg, s4_en1_reg}),
        .out_valid (d1_v),
        .quot      (q1),
        .side_out  (d1_side)
    );

    qrs_div_pipe #(
        .SIDE_W (1)
    ) u_div_two (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s4_v_reg),
        .num       (s4_num2_reg),
        .den       (s4_den2_reg),
        .side_in   (s4_en2_reg),
        .out_valid (d2_v),
        .quot      (q2),
        .side_out  (d2_side)
    );

    // Output stage: clip to the root width and zero absent roots.
    logic signed [63:0] q1_wide, q2_wide, r1_clip, r2_clip;
    logic               sat1, sat2;

    always_comb
    begin
        q1_wide = 64'(q1);
        q2_wide = 64'(q2);
        sat1    = (q1_wide > ROOT_MAX) || (q1_wide < ROOT_MIN);
        sat2    = (q2_wide > ROOT_MAX) || (q2_wide < ROOT_MIN);
        r1_clip = (q1_wide > ROOT_MAX) ? ROOT_MAX : ((q1_wide < ROOT_MIN) ? ROOT_MIN : q1_wide);
        r2_clip = (q2_wide > ROOT_MAX) ? ROOT_MAX : ((q2_wide < ROOT_MIN) ? ROOT_MIN : q2_wide);
    end

    logic                         done_reg;
    logic [1:0]                   root_count_reg;
    logic signed [ROOT_WIDTH-1:0] root_one_reg, root_two_reg;
    logic                         saturated_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= d1_v;
        end
    end

    always_ff @(posedge clk)
    begin
        root_count_reg <= d1_side[2:1];
        root_one_reg   <= d1_side[0] ? r1_clip[ROOT_WIDTH-1:0] : '0;
        root_two_reg   <= d2_side ? r2_clip[ROOT_WIDTH-1:0] : '0;
        saturated_reg  <= (d1_side[0] && sat1) || (d2_side && sat2);
    end

    assign done       = done_reg;
    assign root_count = root_count_reg;
    assign root_one   = root_one_reg;
    assign root_two   = root_two_reg;
    assign saturated  = saturated_reg;

    // The two division lanes must stay in lockstep.
    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        d1_v == d2_v)
        else $error("division lanes out of step");

    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("item did not complete at the fixed latency");

    a_absent_roots_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (root_count == qrs_pkg::CNT_NONE || root_count == qrs_pkg::CNT_INF))
        |-> (root_one == '0 && root_two == '0 && !saturated))
        else $error("roots reported with no finite root count");

    a_sat_needs_root: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |->
        (root_count == qrs_pkg::CNT_ONE || root_count == qrs_pkg::CNT_TWO))
        else $error("saturation flagged without a root");

endmodule

`default_nettype wire
